// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the standard clk_i and rst_ni of the enclosing module.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/mrm16_pkg.sv -----
// Package for the MOV r16,r/m16 executor: word types, codes and address helpers.
// No dependencies; imported by every module of the block.
package mrm16_pkg;

  localparam int unsigned MEM_ADDR_BITS_DEF = 16;
  localparam int unsigned PHYS_W = 20;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned REG_W = 3;
  localparam int unsigned NUM_REGS = 8;

  localparam logic [7:0] OP_MOV = 8'h8B;
  localparam logic [7:0] OP_NOP = 8'h90;

  localparam logic [1:0] MOD_NONE = 2'b00;
  localparam logic [1:0] MOD_DISP8 = 2'b01;
  localparam logic [1:0] MOD_DISP16 = 2'b10;
  localparam logic [1:0] MOD_REG = 2'b11;
  localparam logic [2:0] RM_DIRECT = 3'b110;

  localparam logic [REG_W-1:0] REG_BX = 3'd3;
  localparam logic [REG_W-1:0] REG_BP = 3'd5;
  localparam logic [REG_W-1:0] REG_SI = 3'd6;
  localparam logic [REG_W-1:0] REG_DI = 3'd7;

  typedef enum logic [1:0] {
    FUNC_EXEC   = 2'd0,
    FUNC_MEM_WR = 2'd1,
    FUNC_REG_WR = 2'd2,
    FUNC_REG_RD = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_ACCESS = 2'd0,
    ST_MOV    = 2'd1,
    ST_NOP    = 2'd2,
    ST_UNSUP  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       opcode;
    logic [7:0]       modrm;
    logic [7:0]       disp_low;
    logic [7:0]       disp_high;
    logic [15:0]      mem_address;
    logic [15:0]      write_data;
    logic [REG_W-1:0] reg_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [REG_W-1:0] dest_reg;
    logic [15:0]      result_value;
    logic [15:0]      effective_address;
    logic [15:0]      phys_address;
    logic [2:0]       instr_length;
    logic [15:0]      instr_pointer;
  } out_word_t;

  typedef struct packed {
    logic              en;
    logic [REG_W-1:0]  idx;
    logic [WORD_W-1:0] data;
  } reg_wr_t;

  typedef struct packed {
    logic [WORD_W-1:0] bx;
    logic [WORD_W-1:0] bp;
    logic [WORD_W-1:0] si;
    logic [WORD_W-1:0] di;
  } base_regs_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [PHYS_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  function automatic logic [PHYS_W-1:0] phys_sum(input logic [15:0] seg,
                                                 input logic [15:0] offset);
    return {seg, 4'h0} + {4'h0, offset};
  endfunction

  function automatic logic [PHYS_W-1:0] addr_mask(input int unsigned bits);
    return {PHYS_W{1'b1}} >> (PHYS_W - bits);
  endfunction

endpackage

// ----- rtl/core/mrm16_dmem.sv -----
// Single-port byte data memory with a registered read port.
// Depends on mrm16_pkg for the request type.
module mrm16_dmem import mrm16_pkg::*; #(
  parameter int unsigned MemAddrBits = MEM_ADDR_BITS_DEF
) (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [2**MemAddrBits];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[req_i.addr[MemAddrBits-1:0]] <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[req_i.addr[MemAddrBits-1:0]];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mrm16_regs.sv -----
// General register file with two ordered write ports and a bypass of the older one.
// Depends on mrm16_pkg for the write and base register types.
module mrm16_regs import mrm16_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  reg_wr_t          commit_wr_i,
  input  reg_wr_t          issue_wr_i,
  input  logic [REG_W-1:0] rd_idx_i,
  output logic [WORD_W-1:0] rd_data_o,
  output base_regs_t       base_o
);

  logic [WORD_W-1:0] regs_q [NUM_REGS];
  logic [WORD_W-1:0] view [NUM_REGS];

  // The commit port retires an older memory load in the same cycle a new word reads.
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      view[i] = (commit_wr_i.en && commit_wr_i.idx == REG_W'(i)) ? commit_wr_i.data
                                                                  : regs_q[i];
    end
  end

  assign rd_data_o = view[rd_idx_i];
  assign base_o.bx = view[REG_BX];
  assign base_o.bp = view[REG_BP];
  assign base_o.si = view[REG_SI];
  assign base_o.di = view[REG_DI];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= (REG_W'(i) == REG_BX) ? WORD_W'(1) : '0;
      end
    end else begin
      if (commit_wr_i.en) begin
        regs_q[commit_wr_i.idx] <= commit_wr_i.data;
      end
      if (issue_wr_i.en) begin
        regs_q[issue_wr_i.idx] <= issue_wr_i.data;
      end
    end
  end

endmodule

// ----- rtl/core/mrm16_agu.sv -----
// Effective address unit: ModRM base/index sum, displacement and physical address.
// Depends on mrm16_pkg for base register type and address helpers.
module mrm16_agu import mrm16_pkg::*; #(
  parameter int unsigned MemAddrBits = MEM_ADDR_BITS_DEF
) (
  input  logic [15:0]       seg_i,
  input  logic [7:0]        modrm_i,
  input  logic [7:0]        disp_low_i,
  input  logic [7:0]        disp_high_i,
  input  base_regs_t        base_i,
  output logic [15:0]       ea_o,
  output logic [PHYS_W-1:0] phys_o,
  output logic [2:0]        len_o
);

  localparam logic [PHYS_W-1:0] AddrMask = addr_mask(MemAddrBits);

  logic [1:0]  mod_f;
  logic [2:0]  rm_f;
  logic [15:0] base_sum;
  logic [15:0] disp;

  assign mod_f = modrm_i[7:6];
  assign rm_f  = modrm_i[2:0];

  always_comb begin
    case (rm_f)
      3'd0:    base_sum = base_i.bx + base_i.si;
      3'd1:    base_sum = base_i.bx + base_i.di;
      3'd2:    base_sum = base_i.bp + base_i.si;
      3'd3:    base_sum = base_i.bp + base_i.di;
      3'd4:    base_sum = base_i.si;
      3'd5:    base_sum = base_i.di;
      3'd6:    base_sum = (mod_f == MOD_NONE) ? 16'h0000 : base_i.bp;
      default: base_sum = base_i.bx;
    endcase
  end

  always_comb begin
    disp  = 16'h0000;
    len_o = 3'd2;
    if (mod_f == MOD_DISP8) begin
      disp  = {{8{disp_low_i[7]}}, disp_low_i};
      len_o = 3'd3;
    end else if (mod_f == MOD_DISP16 || (mod_f == MOD_NONE && rm_f == RM_DIRECT)) begin
      disp  = {disp_high_i, disp_low_i};
      len_o = 3'd4;
    end
  end

  assign ea_o   = base_sum + disp;
  assign phys_o = phys_sum(seg_i, ea_o) & AddrMask;

endmodule

// ----- rtl/core/mov_reg_rm16_executor.sv -----
// Pipeline: an accepted word is registered in stage 1 and then in the output
// register; a MOV with a memory operand stays in stage 1 while its high byte is read.
// Throughput: one word per cycle while the output is not stalled, except a
// memory-operand MOV, which holds the single byte port of the data memory for its high byte read.
// Reset: BX is 1, the other registers, the IP and the data segment are 0; the
// data memory is not cleared and holds unknown bytes until written.
module mov_reg_rm16_executor import mrm16_pkg::*; #(
  parameter int unsigned MemAddrBits = MEM_ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o
);

  localparam logic [PHYS_W-1:0] AddrMask = addr_mask(MemAddrBits);

  logic [15:0]       seg_q;
  logic [15:0]       ip_q, ip_d;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_mem_q;
  logic              s1_phase_q;
  out_word_t         s1_word_q;
  logic [7:0]        lo_q;
  logic              out_valid_q;
  out_word_t         out_word_q;

  in_word_t          w;
  logic [1:0]        mod_f;
  logic [REG_W-1:0]  reg_f;
  logic [2:0]        rm_f;
  logic [15:0]       agu_ea;
  logic [PHYS_W-1:0] agu_phys;
  logic [2:0]        agu_len;
  logic [PHYS_W-1:0] wr_phys;
  logic [PHYS_W-1:0] hi_phys;
  logic [REG_W-1:0]  rd_idx;
  logic [WORD_W-1:0] rd_data;
  base_regs_t        base;
  reg_wr_t           issue_wr, commit_wr;
  mem_req_t          mem_req;
  logic [7:0]        mem_rdata;
  logic [15:0]       mem_value;
  out_word_t         s1_new;
  out_word_t         s1_out;
  logic              new_mem;
  logic              out_ready, s1_done, s1_leave, in_ready, accept, hi_cycle;

  assign w     = in_word_i;
  assign mod_f = w.modrm[7:6];
  assign reg_f = w.modrm[5:3];
  assign rm_f  = w.modrm[2:0];

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_done   = !s1_mem_q || s1_phase_q;
  assign s1_leave  = s1_valid_q && s1_done && out_ready;
  assign in_ready  = !s1_valid_q || s1_leave;
  assign accept    = in_valid_i && in_ready;
  assign hi_cycle  = s1_valid_q && s1_mem_q && !s1_phase_q;

  assign wr_phys   = {4'h0, w.mem_address} & AddrMask;
  assign hi_phys   = phys_sum(seg_q, s1_word_q.effective_address + 16'd1) & AddrMask;
  assign rd_idx    = (w.func == FUNC_REG_RD) ? w.reg_index : rm_f;
  assign mem_value = {mem_rdata, lo_q};

  mrm16_agu #(
    .MemAddrBits(MemAddrBits)
  ) u_agu (
    .seg_i      (seg_q),
    .modrm_i    (w.modrm),
    .disp_low_i (w.disp_low),
    .disp_high_i(w.disp_high),
    .base_i     (base),
    .ea_o       (agu_ea),
    .phys_o     (agu_phys),
    .len_o      (agu_len)
  );

  mrm16_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_wr_i(commit_wr),
    .issue_wr_i (issue_wr),
    .rd_idx_i   (rd_idx),
    .rd_data_o  (rd_data),
    .base_o     (base)
  );

  mrm16_dmem #(
    .MemAddrBits(MemAddrBits)
  ) u_dmem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    s1_new   = '0;
    new_mem  = 1'b0;
    issue_wr = '0;
    case (w.func)
      FUNC_MEM_WR: begin
        s1_new.status        = ST_ACCESS;
        s1_new.result_value  = {8'h00, w.write_data[7:0]};
        s1_new.phys_address  = wr_phys[15:0];
      end
      FUNC_REG_WR: begin
        s1_new.status       = ST_ACCESS;
        s1_new.dest_reg     = w.reg_index;
        s1_new.result_value = w.write_data;
        issue_wr.en   = accept;
        issue_wr.idx  = w.reg_index;
        issue_wr.data = w.write_data;
      end
      FUNC_REG_RD: begin
        s1_new.status       = ST_ACCESS;
        s1_new.dest_reg     = w.reg_index;
        s1_new.result_value = rd_data;
      end
      default: begin
        if (w.opcode == OP_MOV) begin
          s1_new.status   = ST_MOV;
          s1_new.dest_reg = reg_f;
          if (mod_f == MOD_REG) begin
            s1_new.result_value = rd_data;
            s1_new.instr_length = 3'd2;
            issue_wr.en   = accept;
            issue_wr.idx  = reg_f;
            issue_wr.data = rd_data;
          end else begin
            new_mem                  = 1'b1;
            s1_new.effective_address = agu_ea;
            s1_new.phys_address      = agu_phys[15:0];
            s1_new.instr_length      = agu_len;
          end
        end else begin
          s1_new.status       = (w.opcode == OP_NOP) ? ST_NOP : ST_UNSUP;
          s1_new.instr_length = 3'd1;
        end
      end
    endcase
    s1_new.instr_pointer = ip_q + 16'(s1_new.instr_length);
  end

  always_comb begin
    commit_wr.en   = s1_leave && s1_mem_q;
    commit_wr.idx  = s1_word_q.dest_reg;
    commit_wr.data = mem_value;
  end

  always_comb begin
    s1_out = s1_word_q;
    if (s1_mem_q) begin
      s1_out.result_value = mem_value;
    end
  end

  always_comb begin
    mem_req = '0;
    if (hi_cycle) begin
      mem_req.en   = 1'b1;
      mem_req.addr = hi_phys;
    end else if (accept && w.func == FUNC_MEM_WR) begin
      mem_req.en    = 1'b1;
      mem_req.we    = 1'b1;
      mem_req.addr  = wr_phys;
      mem_req.wdata = w.write_data[7:0];
    end else if (accept && new_mem) begin
      mem_req.en   = 1'b1;
      mem_req.addr = agu_phys;
    end
  end

  assign ip_d = accept ? s1_new.instr_pointer : ip_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_leave) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= '0;
      ip_q        <= '0;
      s1_valid_q  <= 1'b0;
      s1_mem_q    <= 1'b0;
      s1_phase_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seg_q <= cfg_data_i;
      end
      ip_q       <= ip_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        s1_mem_q   <= new_mem;
        s1_phase_q <= 1'b0;
      end else if (hi_cycle) begin
        s1_phase_q <= 1'b1;
      end
      if (s1_leave) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q <= s1_new;
    end
    if (hi_cycle) begin
      lo_q <= mem_rdata;
    end
    if (s1_leave) begin
      out_word_q <= s1_out;
    end
  end

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- rtl/core/mrm16_checker.sv -----
// Port-level checker for the MOV r16,r/m16 executor, bound to the top level.
// Depends on mrm16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrm16_checker import mrm16_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "output word dropped while stalled")
  `ASSERT_STD(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_word_o), "stalled output word changed")
  `ASSERT_STD(a_nop_fields, out_valid_o && (out_word_o.status == ST_NOP || out_word_o.status == ST_UNSUP) |-> out_word_o.instr_length == 3'd1 && out_word_o.effective_address == 16'h0000 && out_word_o.dest_reg == 3'd0, "nop word has bad fields")
  `ASSERT_STD(a_mov_len, out_valid_o && out_word_o.status == ST_MOV |-> out_word_o.instr_length == 3'd2 || out_word_o.instr_length == 3'd3 || out_word_o.instr_length == 3'd4, "mov word has bad length")
  `ASSERT_STD(a_access_len, out_valid_o && out_word_o.status == ST_ACCESS |-> out_word_o.instr_length == 3'd0 && out_word_o.effective_address == 16'h0000, "access word has bad fields")

endmodule

bind mov_reg_rm16_executor mrm16_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);
